@@ design/ple_pkg.sv @@
// package for the positional list engine
// list depth, field widths, action, status and cell control codes
// no dependencies
`default_nettype none

package ple_pkg;

	localparam int DEPTH     = 64;
	localparam int WORD_W    = 32;
	localparam int ACT_W     = 3;
	localparam int POS_W     = 7;
	localparam int ST_W      = 2;
	localparam int CNT_OUT_W = 7;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0]         fill_t;

	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_INSERT_AT  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_POP_AT     = 3'd5;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_INS  = 2'd1;
	localparam logic [1:0] OP_REM  = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic       at;
		logic       past;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ design/ple_req_if.sv @@
// request and response channels of the positional list engine
// depends on ple_pkg
`default_nettype none

interface ple_req_if;
	import ple_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ACT_W-1:0]     action;
	logic [POS_W-1:0]     position;
	word_t                value;

	modport source (output valid, action, position, value, input ready);
	modport sink   (input valid, action, position, value, output ready);
endinterface

interface ple_rsp_if;
	import ple_pkg::*;

	logic                 valid;
	logic                 ready;
	word_t                popped;
	logic [ST_W-1:0]      status;
	logic [CNT_OUT_W-1:0] count;

	modport source (output valid, popped, status, count, input ready);
	modport sink   (input valid, popped, status, count, output ready);
endinterface

`default_nettype wire

@@ design/ple_cell.sv @@
// one storage cell of the list: holds one entry, shifts with its neighbors
// depends on ple_pkg
`default_nettype none

module ple_cell (
	input  wire logic              clk,
	input  wire ple_pkg::cell_ctl_t ctl,
	input  wire ple_pkg::word_t    word,
	input  wire ple_pkg::word_t    left,
	input  wire ple_pkg::word_t    right,
	output ple_pkg::word_t         data_q,
	output ple_pkg::word_t         tap
);
	import ple_pkg::*;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INS: begin
				if (ctl.past) begin
					data_q <= left;
				end else if (ctl.at) begin
					data_q <= word;
				end
			end
			OP_REM: begin
				if (ctl.at || ctl.past) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign tap = ctl.at ? data_q : '0;

endmodule

`default_nettype wire

@@ design/positional_list_engine.sv @@
// top level of the positional list engine: decode, row of cells, result register
// depends on ple_pkg, ple_req_if, ple_rsp_if and ple_cell
//
// usage
//  req carries one action (push front/back, pop front/back, insert at, pop at)
//  with a position and a value; rsp returns popped word, status and new count
//  every transfer on req produces exactly one transfer on rsp
//  latency: the result is shown the cycle after the request transfer
//  throughput: one item per cycle; every entry lives in its own cell and all
//  cells shift at once, so the action finishes in the accept cycle
//  the single result register is the only buffer: req.ready is high while it is
//  empty or being drained, so a stalled receiver holds off new requests
//  reset clears the count and the response valid flag; entries need no clearing
//  since only entries below the count are ever read
`default_nettype none

module positional_list_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);
	import ple_pkg::*;

	fill_t              fill_q;
	logic               acc;
	logic [CMP_W-1:0]   cnt_x;
	logic [CMP_W-1:0]   pos_x;
	logic [CMP_W-1:0]   k;
	logic [1:0]         op;
	logic [ST_W-1:0]    status_d;
	fill_t              fill_d;
	logic               is_full;
	logic               is_empty;
	word_t              tap_or;
	word_t              cell_q [DEPTH];
	word_t              tap [DEPTH];

	assign req.ready = !rsp.valid || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign cnt_x     = CMP_W'(fill_q);
	assign pos_x     = CMP_W'(req.position);
	assign is_full   = (fill_q == CNT_W'(DEPTH));
	assign is_empty  = (fill_q == '0);

	always_comb begin
		op       = OP_HOLD;
		k        = '0;
		status_d = ST_DONE;
		case (req.action)
			ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT_AT: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					op = OP_INS;
					if (req.action == ACT_PUSH_BACK) begin
						k = cnt_x;
					end else if (req.action == ACT_INSERT_AT) begin
						k = (pos_x >= cnt_x) ? cnt_x : pos_x;
					end
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					op = OP_REM;
					if (req.action == ACT_POP_BACK) begin
						k = cnt_x - CMP_W'(1);
					end
				end
			end
			ACT_POP_AT: begin
				if (pos_x >= cnt_x) begin
					status_d = ST_EMPTY;
				end else begin
					op = OP_REM;
					k  = pos_x;
				end
			end
			default: begin
			end
		endcase
		if (!acc) begin
			op = OP_HOLD;
		end
	end

	always_comb begin
		case (op)
			OP_INS:  fill_d = fill_q + CNT_W'(1);
			OP_REM:  fill_d = fill_q - CNT_W'(1);
			default: fill_d = fill_q;
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t ctl;
		word_t     left;
		word_t     right;

		assign ctl = {op, (k == CMP_W'(i)), (k < CMP_W'(i))};

		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_left
			assign left = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_right
			assign right = cell_q[i+1];
		end

		ple_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.word   (req.value),
			.left   (left),
			.right  (right),
			.data_q (cell_q[i]),
			.tap    (tap[i])
		);
	end

	always_comb begin
		tap_or = '0;
		for (int j = 0; j < DEPTH; j++) begin
			tap_or = tap_or | tap[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			rsp.valid <= 1'b0;
		end else begin
			if (acc) begin
				fill_q    <= fill_d;
				rsp.valid <= 1'b1;
			end else if (rsp.ready) begin
				rsp.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp.popped <= (op == OP_REM) ? tap_or : '0;
			rsp.status <= status_d;
			rsp.count  <= CNT_OUT_W'(fill_d);
		end
	end

	a_fill_bound : assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_full_status : assert property (@(posedge clk) disable iff (!arst_n)
		acc && status_d == ST_FULL |=> rsp.valid && rsp.popped == '0 && fill_q == CNT_W'(DEPTH))
		else $error("dropped insert changed the list or returned data");

	a_empty_status : assert property (@(posedge clk) disable iff (!arst_n)
		acc && status_d == ST_EMPTY |=> rsp.popped == '0 && $stable(fill_q))
		else $error("empty pop changed the count or returned data");

	a_count_step : assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(fill_q))
		else $error("count changed without a transfer");

endmodule

`default_nettype wire
